### rtl/ffca_pkg.sv
`timescale 1ns / 1ps

package ffca_pkg;

   // width of the capacity and request fields on the input channel
   localparam int FIELD_WIDTH = 32;

   // item kinds on the input channel
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_ALLOC = 1'b1;

   // controller sequence
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LD_DESC,
      ST_AL_ROOT,
      ST_AL_DESC,
      ST_AL_LEAF,
      ST_UP,
      ST_RESULT
   } state_type;

endpackage

### rtl/ffca_if.sv
`timescale 1ns / 1ps

// input channel: load or allocate items
interface ffca_req_if
   import ffca_pkg::*;
#(
   parameter int SLOT_WIDTH = 10
);

   logic                    valid;
   logic                    ready;
   logic                    req_type;
   logic [SLOT_WIDTH-1:0]   slot_index;
   logic [FIELD_WIDTH-1:0]  load_capacity;
   logic [FIELD_WIDTH-1:0]  request_size;

   modport source (
      output valid, req_type, slot_index, load_capacity, request_size,
      input  ready
   );
   modport sink (
      input  valid, req_type, slot_index, load_capacity, request_size,
      output ready
   );
endinterface

// result channel: allocation outcome
interface ffca_rsp_if #(
   parameter int SLOT_WIDTH = 10
);
   logic                  valid;
   logic                  ready;
   logic                  found;
   logic [SLOT_WIDTH-1:0] granted_slot;

   modport source (
      output valid, found, granted_slot,
      input  ready
   );
   modport sink (
      input  valid, found, granted_slot,
      output ready
   );
endinterface

### rtl/ffca_tree_mem.sv
`timescale 1ns / 1ps

module ffca_tree_mem #(
   parameter int DEPTH      = 4096,
   parameter int ADDR_WIDTH = 12,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] tree_mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tree_mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= tree_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ffca_ctrl.sv
`timescale 1ns / 1ps

module ffca_ctrl
   import ffca_pkg::*;
#(
   parameter int NUM_SLOTS  = 1024,
   parameter int CAP_WIDTH  = 32,
   parameter int SLOT_WIDTH = 10,
   parameter int ADDR_WIDTH = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   ffca_req_if.sink              req_if,
   // tree memory
   output logic                  mem_wr_en,
   output logic [ADDR_WIDTH-1:0] mem_wr_addr,
   output logic [CAP_WIDTH-1:0]  mem_wr_data,
   output logic                  mem_rd_en,
   output logic [ADDR_WIDTH-1:0] mem_rd_addr,
   input  logic [CAP_WIDTH-1:0]  mem_rd_data,
   // result toward the output register
   input  logic                  out_free,
   output logic                  res_valid,
   output logic                  res_found,
   output logic [SLOT_WIDTH-1:0] res_slot
);

   localparam int CMP_WIDTH  = (CAP_WIDTH > FIELD_WIDTH) ? CAP_WIDTH : FIELD_WIDTH;
   localparam int NODE_COUNT = 4 * NUM_SLOTS;
   localparam logic [ADDR_WIDTH-1:0] ROOT_NODE  = ADDR_WIDTH'(1);
   localparam logic [ADDR_WIDTH-1:0] LAST_NODE  = ADDR_WIDTH'(NODE_COUNT - 1);
   localparam logic [SLOT_WIDTH-1:0] LAST_SLOT  = SLOT_WIDTH'(NUM_SLOTS - 1);
   localparam logic [SLOT_WIDTH:0]   SLOT_LIMIT = (SLOT_WIDTH + 1)'(NUM_SLOTS);

   state_type              state_ff, state_in;
   logic [ADDR_WIDTH-1:0]  clr_ff, clr_in;
   logic                   is_alloc_ff, is_alloc_in;
   logic [SLOT_WIDTH-1:0]  slot_ff, slot_in;
   logic [CAP_WIDTH-1:0]   cap_ff, cap_in;
   logic [FIELD_WIDTH-1:0] size_ff, size_in;
   logic [SLOT_WIDTH-1:0]  lo_ff, lo_in;
   logic [SLOT_WIDTH-1:0]  hi_ff, hi_in;
   logic [ADDR_WIDTH-1:0]  node_ff, node_in;
   logic [CAP_WIDTH-1:0]   cur_ff, cur_in;
   logic                   found_ff, found_in;

   logic                   req_fire;
   logic                   slot_ok;
   logic [SLOT_WIDTH-1:0]  mid;
   logic                   range_open;
   logic                   fits;
   logic                   step_left;
   logic [SLOT_WIDTH-1:0]  nxt_lo;
   logic [SLOT_WIDTH-1:0]  nxt_hi;
   logic [ADDR_WIDTH-1:0]  nxt_node;
   logic                   nxt_open;
   logic [ADDR_WIDTH-1:0]  parent;
   logic [CAP_WIDTH-1:0]   up_max;
   logic [CMP_WIDTH-1:0]   leaf_diff;

   // shared descent and ascent arithmetic
   assign req_fire   = req_if.valid && req_if.ready;
   assign slot_ok    = {1'b0, req_if.slot_index} < SLOT_LIMIT;
   assign mid        = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign range_open = lo_ff < hi_ff;
   assign fits       = CMP_WIDTH'(mem_rd_data) >= CMP_WIDTH'(size_ff);
   assign step_left  = (state_ff == ST_AL_DESC) ? fits : (slot_ff <= mid);
   assign nxt_lo     = step_left ? lo_ff : mid + SLOT_WIDTH'(1);
   assign nxt_hi     = step_left ? mid : hi_ff;
   assign nxt_node   = {node_ff[ADDR_WIDTH-2:0], ~step_left};
   assign nxt_open   = nxt_lo < nxt_hi;
   assign parent     = node_ff >> 1;
   assign up_max     = (cur_ff > mem_rd_data) ? cur_ff : mem_rd_data;
   assign leaf_diff  = CMP_WIDTH'(mem_rd_data) - CMP_WIDTH'(size_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_if.req_type == REQ_ALLOC) begin
                  state_in = ST_AL_ROOT;
               end else if (slot_ok) begin
                  state_in = ST_LD_DESC;
               end
            end
         end
         ST_LD_DESC: begin
            if (!range_open) begin
               state_in = ST_UP;
            end
         end
         ST_AL_ROOT: begin
            state_in = fits ? ST_AL_DESC : ST_RESULT;
         end
         ST_AL_DESC: begin
            if (!nxt_open) begin
               state_in = ST_AL_LEAF;
            end
         end
         ST_AL_LEAF: begin
            state_in = fits ? ST_UP : ST_RESULT;
         end
         ST_UP: begin
            if (parent == ROOT_NODE) begin
               state_in = is_alloc_ff ? ST_RESULT : ST_IDLE;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      clr_in      = clr_ff;
      is_alloc_in = is_alloc_ff;
      slot_in     = slot_ff;
      cap_in      = cap_ff;
      size_in     = size_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      node_in     = node_ff;
      cur_in      = cur_ff;
      found_in    = found_ff;
      req_if.ready = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = node_ff;
      mem_wr_data = cur_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = node_ff ^ ROOT_NODE;
      res_valid   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            // zero one node per cycle
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + ADDR_WIDTH'(1);
         end
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_fire) begin
               is_alloc_in = req_if.req_type == REQ_ALLOC;
               slot_in     = req_if.slot_index;
               cap_in      = CAP_WIDTH'(req_if.load_capacity);
               size_in     = req_if.request_size;
               lo_in       = '0;
               hi_in       = LAST_SLOT;
               node_in     = ROOT_NODE;
               if (req_if.req_type == REQ_ALLOC) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = ROOT_NODE;
               end
            end
         end
         ST_LD_DESC: begin
            if (range_open) begin
               lo_in   = nxt_lo;
               hi_in   = nxt_hi;
               node_in = nxt_node;
            end else begin
               // write the leaf, fetch its sibling
               mem_wr_en   = 1'b1;
               mem_wr_addr = node_ff;
               mem_wr_data = cap_ff;
               cur_in      = cap_ff;
               mem_rd_en   = 1'b1;
               mem_rd_addr = node_ff ^ ROOT_NODE;
            end
         end
         ST_AL_ROOT: begin
            if (fits) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = {node_ff[ADDR_WIDTH-2:0], 1'b0};
            end else begin
               found_in = 1'b0;
            end
         end
         ST_AL_DESC: begin
            // step toward the leftmost child that fits
            lo_in       = nxt_lo;
            hi_in       = nxt_hi;
            node_in     = nxt_node;
            mem_rd_en   = 1'b1;
            mem_rd_addr = nxt_open ? {nxt_node[ADDR_WIDTH-2:0], 1'b0} : nxt_node;
         end
         ST_AL_LEAF: begin
            found_in = fits;
            if (fits) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = node_ff;
               mem_wr_data = CAP_WIDTH'(leaf_diff);
               cur_in      = CAP_WIDTH'(leaf_diff);
               mem_rd_en   = 1'b1;
               mem_rd_addr = node_ff ^ ROOT_NODE;
            end
         end
         ST_UP: begin
            // refresh one ancestor, fetch the next sibling
            mem_wr_en   = 1'b1;
            mem_wr_addr = parent;
            mem_wr_data = up_max;
            cur_in      = up_max;
            node_in     = parent;
            if (parent != ROOT_NODE) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = parent ^ ROOT_NODE;
            end
         end
         ST_RESULT: begin
            res_valid = out_free;
         end
         default: begin
         end
      endcase
   end

   assign res_found = found_ff;
   assign res_slot  = found_ff ? lo_ff : '0;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      is_alloc_ff <= is_alloc_in;
      slot_ff     <= slot_in;
      cap_ff      <= cap_in;
      size_ff     <= size_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      node_ff     <= node_in;
      cur_ff      <= cur_in;
      found_ff    <= found_in;
   end

endmodule

### rtl/first_fit_capacity_allocator.sv
`timescale 1ns / 1ps
// First-fit allocator over a max tree of slot capacities.
// req_if carries load items (set one slot's capacity, no response) and
// allocate items (take request_size from the leftmost slot that holds at
// least that much). Each allocate gives one transfer on rsp_if: found and
// granted_slot, or found low with slot zero when nothing fits.
// Items are worked one at a time through a single tree memory with one
// read and one write port; ceil(log2(NUM_SLOTS)) is the tree height.
// An allocate makes one memory read per level going down, and a load steps
// down without reading; both then make one sibling read and one parent
// write per level going up. An allocate whose root already shows that
// nothing fits skips the descent and goes straight to its response.
// A load beyond the slot range is dropped and the block is ready again
// in the next cycle.
// After reset all 4*NUM_SLOTS tree nodes are zeroed one node per cycle,
// with req_if.ready low. The response sits in an output register; while
// the receiver stalls, the next item is still taken and worked, and its
// response waits until the register drains.
module first_fit_capacity_allocator
   import ffca_pkg::*;
#(
   parameter int NUM_SLOTS = 1024,
   parameter int CAP_WIDTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   ffca_req_if.sink req_if,
   ffca_rsp_if.source rsp_if
);

   localparam int SLOT_WIDTH = $clog2(NUM_SLOTS);
   localparam int NODE_COUNT = 4 * NUM_SLOTS;
   localparam int ADDR_WIDTH = $clog2(NODE_COUNT);

   logic                  mem_wr_en;
   logic [ADDR_WIDTH-1:0] mem_wr_addr;
   logic [CAP_WIDTH-1:0]  mem_wr_data;
   logic                  mem_rd_en;
   logic [ADDR_WIDTH-1:0] mem_rd_addr;
   logic [CAP_WIDTH-1:0]  mem_rd_data;
   logic                  out_free;
   logic                  res_valid;
   logic                  res_found;
   logic [SLOT_WIDTH-1:0] res_slot;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff;
   logic [SLOT_WIDTH-1:0] rsp_slot_ff;

   ffca_tree_mem #(
      .DEPTH      (NODE_COUNT),
      .ADDR_WIDTH (ADDR_WIDTH),
      .DATA_WIDTH (CAP_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ffca_ctrl #(
      .NUM_SLOTS  (NUM_SLOTS),
      .CAP_WIDTH  (CAP_WIDTH),
      .SLOT_WIDTH (SLOT_WIDTH),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .res_found   (res_found),
      .res_slot    (res_slot)
   );

   // output register
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_found_ff <= res_found;
         rsp_slot_ff  <= res_slot;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.found        = rsp_found_ff;
   assign rsp_if.granted_slot = rsp_slot_ff;

   // a new response never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_free)
      else $error("response overwrites a pending transfer");

   // a miss always reports slot zero
   assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_found) |-> (res_slot == '0))
      else $error("miss with nonzero slot");

   // the clearing pass holds off input right after reset
   assert property (@(posedge clock)
      reset |=> !req_if.ready)
      else $error("input taken during clearing pass");

   // a response appears only when one was produced
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !res_valid) |=> !rsp_if.valid)
      else $error("spurious response");

endmodule
